>>> hdl/outlier_rejecting_window_average_top_assert.svh
// Assertion macros shared by the window average block.
// Define ASSERT_OFF to compile every assertion away.
`ifndef OUTLIER_REJECTING_WINDOW_AVERAGE_TOP_ASSERT_SVH
`define OUTLIER_REJECTING_WINDOW_AVERAGE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define ORWA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ORWA_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ORWA_ASSERT(lbl, clk, rst_n, prop, msg)
`define ORWA_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/orwa_pkg.sv
`default_nettype none
package orwa_pkg;

  // Field widths of a transaction.
  localparam int SAMPLE_W = 10;
  localparam int KEPT_W   = 4;
  localparam logic [KEPT_W-1:0] KEPT_MAX = 4'd15;

  // The ten percent band in integers: 9*mean <= 10*x <= 11*mean.
  localparam int SCALE   = 10;
  localparam int BAND_LO = 9;
  localparam int BAND_HI = 11;
  localparam int BND_W   = SAMPLE_W + 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_MEAN,
    ST_DIV1,
    ST_SCAN2,
    ST_BAND,
    ST_DIV2,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

>>> hdl/orwa_div.sv
`default_nettype none
module orwa_div #(
  parameter int NUM_W = 14,
  parameter int DEN_W = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NUM_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]   den_i,
  output logic [NUM_W-1:0]        quot_o,
  output orwa_pkg::div_status_t   stat_o
);
  import orwa_pkg::*;

  // Restoring division, one quotient bit per cycle. The dividend register
  // shifts out at the top and collects quotient bits at the bottom.
  localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   rem_sh, diff;
  logic             fits;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = ~diff[DEN_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], fits};
    end
  end

  assign quot_o      = num_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

>>> hdl/outlier_rejecting_window_average_top.sv
// A new transaction is accepted only after the last one has reached the output register,
//   since the block runs two sequential scans of the window memory and up to two
//   bit-serial divisions of SUM_W steps each for every transaction.
// Reset: asynchronous, active low; the window reads as all zero and the slot pointer is zero.
`default_nettype none
`include "outlier_rejecting_window_average_top_assert.svh"
module outlier_rejecting_window_average_top #(
  parameter int WINDOW = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [orwa_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [orwa_pkg::SAMPLE_W-1:0]       filtered_value_o,
  output logic [orwa_pkg::KEPT_W-1:0]         kept_count_o
);
  import orwa_pkg::*;

  // Derived sizes. The largest window sum needs SUM_W bits and a count
  // of up to WINDOW needs CNT_W bits.
  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
  localparam int CNT_W = $clog2(WINDOW + 1);

  // The window lives in a one-port-write, one-port-read memory with a
  // registered read. A valid bit per entry stands in for the reset value:
  // an entry that was never written reads as zero.
  logic [SAMPLE_W-1:0] mem_q [WINDOW];
  logic [WINDOW-1:0]   entry_vld_q;
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                rd_vld_q;
  logic                rd_live_q;

  logic [IDX_W-1:0]    newest_q, slot_d;
  logic [IDX_W:0]      scan_cnt_q, scan_cnt_d;
  logic [IDX_W-1:0]    rd_addr;

  state_e              state_q, state_d;

  logic [SUM_W-1:0]    acc_sum_q, acc_sum_d;
  logic [CNT_W-1:0]    acc_cnt_q, acc_cnt_d;
  logic [SAMPLE_W-1:0] mean_q;
  logic [BND_W-1:0]    lo_q, hi_q;
  logic [SAMPLE_W-1:0] res_val_q, res_val_d;
  logic [KEPT_W-1:0]   res_kept_q, res_kept_d;
  logic [SAMPLE_W-1:0] filt_q;
  logic [KEPT_W-1:0]   kept_q;
  logic                out_valid_q, out_valid_d;

  // Controls from the sequencer.
  logic                accept, issue, acc_clr, div_start, mean_load, out_load;
  logic [SAMPLE_W-1:0] cur_x;
  logic [BND_W-1:0]    x10;
  logic                take;

  logic [SUM_W-1:0]    div_quot;
  div_status_t         div_stat;

  assign accept  = in_valid_i && !in_stall_o;
  assign slot_d  = (newest_q == IDX_W'(WINDOW - 1)) ? '0 : newest_q + IDX_W'(1);
  assign rd_addr = scan_cnt_q[IDX_W-1:0];

  // Window memory: the new sample is written on acceptance; the scans
  // start on the following cycle, so a read never meets a pending write.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[slot_d] <= sample_i;
    end
    if (issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      newest_q    <= '0;
      rd_vld_q    <= 1'b0;
      rd_live_q   <= 1'b0;
    end else begin
      if (accept) begin
        entry_vld_q[slot_d] <= 1'b1;
        newest_q            <= slot_d;
      end
      if (issue) begin
        rd_vld_q <= entry_vld_q[rd_addr];
      end
      rd_live_q <= issue;
    end
  end

  // The entry that came back from memory this cycle, zero when unwritten.
  assign cur_x = rd_vld_q ? rd_data_q : '0;
  assign x10   = BND_W'(cur_x) * BND_W'(SCALE);

  // In the first scan every nonzero entry counts; in the second only the
  // entries inside the band around the first mean.
  always_comb begin
    take = 1'b0;
    if (rd_live_q) begin
      if (state_q == ST_SCAN1) begin
        take = (cur_x != '0);
      end else if (state_q == ST_SCAN2) begin
        take = (x10 >= lo_q) && (x10 <= hi_q);
      end
    end
  end

  always_comb begin
    acc_sum_d = acc_sum_q;
    acc_cnt_d = acc_cnt_q;
    if (acc_clr) begin
      acc_sum_d = '0;
      acc_cnt_d = '0;
    end else if (take) begin
      acc_sum_d = acc_sum_q + SUM_W'(cur_x);
      acc_cnt_d = acc_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_sum_q <= acc_sum_d;
    acc_cnt_q <= acc_cnt_d;
    if (mean_load) begin
      mean_q <= SAMPLE_W'(div_quot);
      lo_q   <= BND_W'(SAMPLE_W'(div_quot)) * BND_W'(BAND_LO);
      hi_q   <= BND_W'(SAMPLE_W'(div_quot)) * BND_W'(BAND_HI);
    end
    res_val_q  <= res_val_d;
    res_kept_q <= res_kept_d;
  end

  orwa_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_sum_q),
    .den_i   (acc_cnt_q),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  // Sequencer: scan, divide, scan again, divide, then hand the result to the
  // output register; a divide is skipped when its count is zero. A new transaction
  // is taken only in idle, while a finished result may still wait in the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    in_stall_o = 1'b1;
    issue      = 1'b0;
    acc_clr    = 1'b0;
    div_start  = 1'b0;
    mean_load  = 1'b0;
    out_load   = 1'b0;
    res_val_d  = res_val_q;
    res_kept_d = res_kept_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        acc_clr    = 1'b1;
        scan_cnt_d = '0;
        if (in_valid_i) begin
          state_d = ST_SCAN1;
        end
      end
      ST_SCAN1, ST_SCAN2: begin
        if (scan_cnt_q < (IDX_W + 1)'(WINDOW)) begin
          issue      = 1'b1;
          scan_cnt_d = scan_cnt_q + (IDX_W + 1)'(1);
        end else if (rd_live_q) begin
          state_d = (state_q == ST_SCAN1) ? ST_MEAN : ST_BAND;
        end
      end
      ST_MEAN: begin
        if (acc_cnt_q == '0) begin
          res_val_d  = '0;
          res_kept_d = '0;
          state_d    = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_stat.done) begin
          mean_load  = 1'b1;
          acc_clr    = 1'b1;
          scan_cnt_d = '0;
          state_d    = ST_SCAN2;
        end
      end
      ST_BAND: begin
        if (acc_cnt_q == '0) begin
          res_val_d  = mean_q;
          res_kept_d = '0;
          state_d    = ST_DONE;
        end else begin
          div_start  = 1'b1;
          res_kept_d = (32'(acc_cnt_q) > 32'(KEPT_MAX)) ? KEPT_MAX : KEPT_W'(acc_cnt_q);
          state_d    = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_stat.done) begin
          res_val_d = SAMPLE_W'(div_quot);
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: holds a result until the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filt_q <= res_val_q;
      kept_q <= res_kept_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = filt_q;
  assign kept_count_o     = kept_q;

  `ORWA_ASSERT(a_div_nonzero_den, clk_i, rst_ni, div_start |-> (acc_cnt_q != '0), "division started with zero divisor")
  `ORWA_ASSERT(a_div_idle_start, clk_i, rst_ni, div_start |-> !div_stat.busy, "division started while busy")
  `ORWA_ASSERT(a_div_done_state, clk_i, rst_ni, div_stat.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2), "division finished outside a divide state")
  `ORWA_ASSERT(a_scan_bound, clk_i, rst_ni, 32'(scan_cnt_q) <= WINDOW, "scan counter past the window")
  `ORWA_ASSERT(a_kept_bound, clk_i, rst_ni, out_valid_o |-> (32'(kept_count_o) <= WINDOW), "kept count larger than the window")
  `ORWA_ASSERT_NORST(a_reset_no_out, clk_i, !rst_ni |-> !out_valid_o, "result shown during reset")

endmodule
`default_nettype wire
